@@ rtl/sext_pkg.sv @@
package sext_pkg;

  localparam int MAX_EXTENTS = 16;
  localparam int ADDR_W      = 40;
  localparam int LEN_W       = 32;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int NUM_W       = $clog2(MAX_EXTENTS + 1);
  localparam int SIDX_W      = IDX_W + 2;

  // config register indexes
  localparam logic [1:0] REG_EXTENT_COUNT = 2'd0;
  localparam logic [1:0] REG_VIRTUAL_SIZE = 2'd1;
  localparam logic [1:0] REG_PAST_END     = 2'd2;

  // command word actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // segment kinds
  localparam logic [2:0] KIND_ZERO      = 3'd0;
  localparam logic [2:0] KIND_PHYS      = 3'd1;
  localparam logic [2:0] KIND_DONE      = 3'd2;
  localparam logic [2:0] KIND_ERR_END   = 3'd3;
  localparam logic [2:0] KIND_ERR_TABLE = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] vstart;
    logic [ADDR_W-1:0] pstart;
    logic [ADDR_W-1:0] len;
  } entry_t;

endpackage

@@ rtl/sext_table.sv @@
module sext_table
  import sext_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [MAX_EXTENTS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sparse_extent_read_translator.sv @@
// channel   | direction | handshake            | word
// ----------+-----------+----------------------+----------------------------------
// command   | in        | start & !busy        | action, entry fields, read fields
// config    | in        | cfg_valid & cfg_ready| cfg_index, cfg_data
// result    | out       | strobe (one cycle)   | segment_kind .. last
//
// a load never raises busy; with an empty table a read gives its segment, if its count
// is not zero, and then its status word. otherwise a read runs the range check, the
// binary search steps and a fetch of the found entry, then passes over or hits extents
// in turn and ends with the status word; the table's single read port paces the walk.
// rst is synchronous and clears the sequencer and config registers.
// results cannot be stalled; each stays on the ports for one cycle.
module sparse_extent_read_translator
  import sext_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [3:0]        entry_index,
  input  logic [ADDR_W-1:0] entry_virtual_start,
  input  logic [ADDR_W-1:0] entry_physical_start,
  input  logic [ADDR_W-1:0] entry_length,
  input  logic [ADDR_W-1:0] read_offset,
  input  logic [LEN_W-1:0]  read_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  output logic              strobe,
  output logic [2:0]        segment_kind,
  output logic [ADDR_W-1:0] physical_address,
  output logic [LEN_W-1:0]  segment_length,
  output logic [LEN_W-1:0]  buffer_offset,
  output logic              last
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SRCH, S_RD1, S_RD2, S_GAP, S_HIT, S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // config registers
  logic [NUM_W-1:0]  extent_count;
  logic [ADDR_W-1:0] virtual_size;
  logic              past_end_zero_fill;

  // working registers
  logic [ADDR_W-1:0] off;
  logic [LEN_W-1:0]  count;
  logic [LEN_W-1:0]  bpos;
  logic [ADDR_W-1:0] delta;
  logic [NUM_W-1:0]  n;
  logic signed [SIDX_W-1:0] beg;
  logic signed [SIDX_W-1:0] fin;
  logic signed [SIDX_W-1:0] mid;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  addr_next;
  logic              done_pend;

  entry_t rd;
  entry_t wr;
  logic   wr_en;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign wr.vstart = entry_virtual_start;
  assign wr.pstart = entry_physical_start;
  assign wr.len    = entry_length;
  assign wr_en     = start && !busy && (action == ACT_LOAD) &&
                     ({1'b0, entry_index} < (IDX_W+1)'(MAX_EXTENTS));

  sext_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_index[IDX_W-1:0]),
    .wr_data (wr),
    .rd_addr (addr_next),
    .rd_data (rd)
  );

  // shared datapath terms
  logic [ADDR_W:0]   end_sum;
  logic              over;
  logic [ADDR_W-1:0] fit_len;
  logic [ADDR_W-1:0] gap;
  logic [LEN_W-1:0]  gap_sz;
  logic [ADDR_W:0]   ext_end;
  logic              hit;
  logic [ADDR_W-1:0] rem;
  logic [LEN_W-1:0]  hit_sz;
  logic signed [SIDX_W-1:0] n_m1;
  logic signed [SIDX_W-1:0] beg_inc;

  always_comb begin
    end_sum  = {1'b0, off} + {{(ADDR_W-LEN_W+1){1'b0}}, count};
    over     = end_sum > {1'b0, virtual_size};
    fit_len  = (virtual_size > off) ? virtual_size - off : '0;
    gap      = rd.vstart - off;
    gap_sz   = (gap > {{(ADDR_W-LEN_W){1'b0}}, count}) ? count : gap[LEN_W-1:0];
    ext_end  = {1'b0, rd.vstart} + {1'b0, rd.len};
    hit      = (off >= rd.vstart) && ({1'b0, off} < ext_end);
    rem      = rd.len - delta;
    hit_sz   = (rem > {{(ADDR_W-LEN_W){1'b0}}, count}) ? count : rem[LEN_W-1:0];
    n_m1     = SIDX_W'(n) - SIDX_W'(1);
    beg_inc  = beg + SIDX_W'(1);
    mid      = (beg + fin) >>> 1;
  end

  // table read address
  always_comb begin
    addr_next = addr;
    case (state)
      S_SRCH: begin
        if (beg < fin) begin
          addr_next = mid[IDX_W-1:0];
        end else begin
          addr_next = (beg < 0) ? '0 : beg[IDX_W-1:0];
        end
      end
      S_RD1:   addr_next = mid[IDX_W-1:0] + IDX_W'(1);
      S_HIT: begin
        if (!hit && (beg_inc < SIDX_W'(n))) begin
          addr_next = beg_inc[IDX_W-1:0];
        end
      end
      S_EMIT: begin
        if (beg_inc < SIDX_W'(n)) begin
          addr_next = beg_inc[IDX_W-1:0];
        end
      end
      default: addr_next = addr;
    endcase
  end

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      extent_count       <= '0;
      virtual_size       <= '0;
      past_end_zero_fill <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXTENT_COUNT: extent_count <= cfg_data[NUM_W-1:0];
        REG_VIRTUAL_SIZE: virtual_size <= cfg_data;
        REG_PAST_END:     past_end_zero_fill <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      done_pend <= 1'b0;
    end else begin
      strobe <= 1'b0;
      addr   <= addr_next;
      segment_kind     <= KIND_DONE;
      physical_address <= '0;
      segment_length   <= '0;
      buffer_offset    <= '0;
      last             <= 1'b0;
      if (done_pend) begin
        done_pend    <= 1'b0;
        strobe       <= 1'b1;
        segment_kind <= KIND_DONE;
        last         <= 1'b1;
        state        <= S_IDLE;
      end else begin
        case (state)
          S_IDLE: begin
            if (start && (action == ACT_READ)) begin
              off   <= read_offset;
              count <= read_count;
              bpos  <= '0;
              n     <= (extent_count > NUM_W'(MAX_EXTENTS)) ?
                       NUM_W'(MAX_EXTENTS) : extent_count;
              if (extent_count == '0) begin
                if (read_count != '0) begin
                  strobe           <= 1'b1;
                  segment_kind     <= KIND_PHYS;
                  physical_address <= read_offset;
                  segment_length   <= read_count;
                end
                done_pend <= 1'b1;
                state     <= S_CHECK;
              end else begin
                state <= S_CHECK;
              end
            end
          end
          S_CHECK: begin
            beg <= '0;
            fin <= n_m1;
            if (over) begin
              if (!past_end_zero_fill) begin
                strobe       <= 1'b1;
                segment_kind <= KIND_ERR_END;
                last         <= 1'b1;
                state        <= S_IDLE;
              end else begin
                strobe         <= 1'b1;
                segment_kind   <= KIND_ZERO;
                segment_length <= count - fit_len[LEN_W-1:0];
                buffer_offset  <= fit_len[LEN_W-1:0];
                count          <= fit_len[LEN_W-1:0];
                if (fit_len == '0) begin
                  done_pend <= 1'b1;
                end
                state <= S_SRCH;
              end
            end else if (count == '0) begin
              done_pend <= 1'b1;
            end else begin
              state <= S_SRCH;
            end
          end
          S_SRCH: begin
            if (beg < fin) begin
              state <= S_RD1;
            end else begin
              if (beg < 0) begin
                beg <= '0;
              end
              state <= S_GAP;
            end
          end
          S_RD1: begin
            if (off < rd.vstart) begin
              fin   <= mid - SIDX_W'(1);
              state <= S_SRCH;
            end else if (mid < n_m1) begin
              state <= S_RD2;
            end else begin
              beg   <= mid;
              fin   <= mid;
              state <= S_SRCH;
            end
          end
          S_RD2: begin
            if (off >= rd.vstart) begin
              beg <= mid + SIDX_W'(1);
            end else begin
              beg <= mid;
              fin <= mid;
            end
            state <= S_SRCH;
          end
          S_GAP: begin
            if (off < rd.vstart) begin
              strobe         <= 1'b1;
              segment_kind   <= KIND_ZERO;
              segment_length <= gap_sz;
              buffer_offset  <= bpos;
              count          <= count - gap_sz;
              off            <= off + {{(ADDR_W-LEN_W){1'b0}}, gap_sz};
              bpos           <= bpos + gap_sz;
              if (count == gap_sz) begin
                done_pend <= 1'b1;
              end
            end
            state <= S_HIT;
          end
          S_HIT: begin
            delta <= off - rd.vstart;
            if (hit) begin
              state <= S_EMIT;
            end else if (beg_inc >= SIDX_W'(n)) begin
              strobe       <= 1'b1;
              segment_kind <= KIND_ERR_TABLE;
              last         <= 1'b1;
              state        <= S_IDLE;
            end else begin
              // next entry is being fetched
              beg   <= beg_inc;
              state <= S_GAP;
            end
          end
          S_EMIT: begin
            strobe           <= 1'b1;
            segment_kind     <= KIND_PHYS;
            physical_address <= rd.pstart + delta;
            segment_length   <= hit_sz;
            buffer_offset    <= bpos;
            count            <= count - hit_sz;
            off              <= off + {{(ADDR_W-LEN_W){1'b0}}, hit_sz};
            bpos             <= bpos + hit_sz;
            if (count == hit_sz) begin
              done_pend <= 1'b1;
            end else if (beg_inc >= SIDX_W'(n)) begin
              // last entry used up with bytes left, reported from S_HIT
              state <= S_HIT;
            end else begin
              beg   <= beg_inc;
              state <= S_GAP;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // the status word closes every read
  assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy after status word");

  assert property (@(posedge clk) disable iff (rst)
    strobe && (segment_kind != KIND_PHYS) |-> physical_address == '0)
    else $error("address on non-read segment");

  assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> segment_length == '0)
    else $error("status word with length");

endmodule

@@ tb/tb_sext_pkg.sv @@
package tb_sext_pkg;

  // cycle limit of one run
  localparam int RUN_LIMIT = 200000;

endpackage

@@ tb/sext_checker.sv @@
module sext_checker
  import sext_pkg::*;
  import tb_sext_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              action,
  input  logic [3:0]        entry_index,
  input  logic [ADDR_W-1:0] entry_virtual_start,
  input  logic [ADDR_W-1:0] entry_physical_start,
  input  logic [ADDR_W-1:0] entry_length,
  input  logic [ADDR_W-1:0] read_offset,
  input  logic [LEN_W-1:0]  read_count,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              strobe,
  input  logic [2:0]        segment_kind,
  input  logic [ADDR_W-1:0] physical_address,
  input  logic [LEN_W-1:0]  segment_length,
  input  logic [LEN_W-1:0]  buffer_offset,
  input  logic              last,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [2:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  bofs;
    logic              fin;
  } seg_t;

  seg_t              seg_q[$];
  logic [ADDR_W-1:0] tbl_vs[MAX_EXTENTS];
  logic [ADDR_W-1:0] tbl_ps[MAX_EXTENTS];
  logic [ADDR_W-1:0] tbl_len[MAX_EXTENTS];
  logic [4:0]        ext_num;
  logic [ADDR_W-1:0] vsize;
  logic              fill_mode;

  task automatic push_seg(input logic [2:0] k, input logic [63:0] a, input logic [63:0] l,
                          input logic [63:0] b, input logic f);
    seg_t s;
    s.kind = k;
    s.addr = a[ADDR_W-1:0];
    s.len  = l[LEN_W-1:0];
    s.bofs = b[LEN_W-1:0];
    s.fin  = f;
    seg_q.push_back(s);
  endtask

  // segment list of one read, pushed in emission order
  task automatic translate_read(input logic [ADDR_W-1:0] off_in, input logic [LEN_W-1:0] cnt_in);
    logic [63:0] off, cnt, bpos, vs, ln, sz, fit_len;
    int n, lo, hi, mid;
    off = {24'd0, off_in};
    cnt = {32'd0, cnt_in};
    n = (ext_num > MAX_EXTENTS) ? MAX_EXTENTS : int'(ext_num);
    // empty table passes the read straight through
    if (n == 0) begin
      if (cnt > 0) push_seg(KIND_PHYS, off, cnt, 0, 1'b0);
      push_seg(KIND_DONE, 0, 0, 0, 1'b1);
      return;
    end
    // past the virtual end
    if (off + cnt > {24'd0, vsize}) begin
      if (!fill_mode) begin
        push_seg(KIND_ERR_END, 0, 0, 0, 1'b1);
        return;
      end
      fit_len = ({24'd0, vsize} > off) ? {24'd0, vsize} - off : 64'd0;
      push_seg(KIND_ZERO, 0, cnt - fit_len, fit_len, 1'b0);
      cnt = fit_len;
      if (cnt == 0) begin
        push_seg(KIND_DONE, 0, 0, 0, 1'b1);
        return;
      end
    end
    // binary search for the extent holding the offset
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (off < {24'd0, tbl_vs[mid]}) hi = mid - 1;
      else if (mid < n - 1 && off >= {24'd0, tbl_vs[mid+1]}) lo = mid + 1;
      else begin
        lo = mid;
        hi = mid;
      end
    end
    if (lo < 0) lo = 0;
    // walk forward through gaps and hits
    bpos = 0;
    while (cnt > 0) begin
      vs = {24'd0, tbl_vs[lo]};
      ln = {24'd0, tbl_len[lo]};
      if (off < vs) begin
        sz = vs - off;
        if (sz > cnt) sz = cnt;
        push_seg(KIND_ZERO, 0, sz, bpos, 1'b0);
        cnt -= sz;
        off += sz;
        bpos += sz;
        if (cnt == 0) break;
      end
      if (off >= vs && off < vs + ln) begin
        sz = ln - (off - vs);
        if (sz > cnt) sz = cnt;
        push_seg(KIND_PHYS, {24'd0, tbl_ps[lo]} + (off - vs), sz, bpos, 1'b0);
        cnt -= sz;
        off += sz;
        bpos += sz;
        if (cnt == 0) break;
      end
      lo++;
      if (lo >= n) begin
        push_seg(KIND_ERR_TABLE, 0, 0, 0, 1'b1);
        return;
      end
    end
    push_seg(KIND_DONE, 0, 0, 0, 1'b1);
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    seg_t e;
    if (rst) begin
      seg_q.delete();
      ext_num    = '0;
      vsize      = '0;
      fill_mode  = 1'b0;
      fail_count = 0;
    end else begin
      // result word
      if (strobe) begin
        if (seg_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d addr=%h len=%h bofs=%h last=%b", $time,
                   segment_kind, physical_address, segment_length, buffer_offset, last);
          fail_count++;
        end else begin
          e = seg_q.pop_front();
          if (e.kind !== segment_kind || e.addr !== physical_address ||
              e.len !== segment_length || e.bofs !== buffer_offset || e.fin !== last) begin
            $display("%0t: mismatch expected kind=%0d addr=%h len=%h bofs=%h last=%b", $time,
                     e.kind, e.addr, e.len, e.bofs, e.fin);
            $display("%0t:          actual   kind=%0d addr=%h len=%h bofs=%h last=%b", $time,
                     segment_kind, physical_address, segment_length, buffer_offset, last);
            fail_count++;
          end
        end
      end
      // config word
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXTENT_COUNT: ext_num = cfg_data[4:0];
          REG_VIRTUAL_SIZE: vsize = cfg_data;
          REG_PAST_END:     fill_mode = cfg_data[0];
          default: ;
        endcase
      end
      // command word
      if (start && !busy) begin
        if (action == ACT_LOAD) begin
          tbl_vs[entry_index]  = entry_virtual_start;
          tbl_ps[entry_index]  = entry_physical_start;
          tbl_len[entry_index] = entry_length;
        end else begin
          translate_read(read_offset, read_count);
        end
      end
    end
    pending = seg_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top
  import sext_pkg::*;
  import tb_sext_pkg::*;
();

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              action;
  logic [3:0]        entry_index;
  logic [ADDR_W-1:0] entry_virtual_start;
  logic [ADDR_W-1:0] entry_physical_start;
  logic [ADDR_W-1:0] entry_length;
  logic [ADDR_W-1:0] read_offset;
  logic [LEN_W-1:0]  read_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [ADDR_W-1:0] cfg_data;
  logic              strobe;
  logic [2:0]        segment_kind;
  logic [ADDR_W-1:0] physical_address;
  logic [LEN_W-1:0]  segment_length;
  logic [LEN_W-1:0]  buffer_offset;
  logic              last;
  int                fail_count;
  int                pending;
  int                cycles;

  logic [ADDR_W-1:0] tbl_base;
  logic [ADDR_W-1:0] tbl_end;
  logic [ADDR_W-1:0] off;
  logic [LEN_W-1:0]  cnt;

  sparse_extent_read_translator u_top (.*);

  sext_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // random pause before a word: mostly none, some short, few long
  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 92) repeat ($urandom_range(15, 60)) @(negedge clk);
    else if (r >= 60) repeat ($urandom_range(1, 3)) @(negedge clk);
  endtask

  // present one command word and hold it until taken
  task automatic send_word();
    idle_gap();
    @(negedge clk);
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_load(input logic [3:0] idx, input logic [ADDR_W-1:0] vs,
                           input logic [ADDR_W-1:0] ps, input logic [ADDR_W-1:0] ln);
    action = ACT_LOAD;
    entry_index = idx;
    entry_virtual_start = vs;
    entry_physical_start = ps;
    entry_length = ln;
    read_offset = rand40();
    read_count = $urandom;
    send_word();
  endtask

  task automatic send_read(input logic [ADDR_W-1:0] o, input logic [LEN_W-1:0] c);
    action = ACT_READ;
    read_offset = o;
    read_count = c;
    entry_index = 4'($urandom);
    entry_virtual_start = rand40();
    send_word();
  endtask

  // drain all results, then let a trailing load settle
  task automatic drain();
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (30) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [ADDR_W-1:0] n, input logic [ADDR_W-1:0] vsz,
                           input logic mode);
    drain();
    write_reg(REG_EXTENT_COUNT, n);
    write_reg(REG_VIRTUAL_SIZE, vsz);
    write_reg(REG_PAST_END, {39'($urandom), mode});
  endtask

  // sorted table with small gaps and lengths so reads cross many extents
  task automatic load_sorted();
    logic [ADDR_W-1:0] cur;
    tbl_base = {1'b0, 39'(rand40())};
    cur = tbl_base;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if ($urandom_range(0, 2) != 0) cur += 40'($urandom_range(1, 300));
      send_load(4'(i), cur, rand40(),
                ($urandom_range(0, 9) == 0) ? 40'd0 : 40'($urandom_range(1, 400)));
      cur += entry_length;
    end
    tbl_end = cur;
  endtask

  task automatic load_noise();
    for (int i = 0; i < MAX_EXTENTS; i++) send_load(4'(i), rand40(), rand40(), rand40());
    tbl_base = 0;
    tbl_end = 40'hFF_FFFF_FFFF;
  endtask

  initial begin
    int mode_sel;
    logic noise;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_LOAD;
    entry_index = '0;
    entry_virtual_start = '0;
    entry_physical_start = '0;
    entry_length = '0;
    read_offset = '0;
    read_count = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_EXTENT_COUNT;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // pass-through with an empty table
    send_read(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_read(40'd0, 32'd0);
    send_read(40'd12345, 32'd77);

    // fixed table: extents of 60 bytes every 100 from 1000, last one near address wrap
    for (int i = 0; i < MAX_EXTENTS; i++)
      send_load(4'(i), 40'(1000 + i * 100),
                (i == 15) ? 40'hFF_FFFF_FFF0 : 40'(40'h10_0000_0000 * i), 40'd60);
    configure(16, 4000, 1'b0);
    send_read(1010, 20);      // inside one extent
    send_read(1070, 100);     // gap, one extent, then a gap
    send_read(500, 600);      // before the first extent
    send_read(1000, 0);       // empty read
    send_read(2500, 100);     // table exhausted after a hit
    send_read(2570, 10);      // table exhausted at once
    send_read(3990, 20);      // past end, error mode
    send_read(2530, 20);      // physical address wraps
    configure(16, 4000, 1'b1);
    send_read(3990, 20);      // fill past end, rest exhausts table
    send_read(5000, 30);      // entirely past end
    send_read(0, 32'hFFFF_FFFF);
    configure({35'h7_FFFF_FFFF, 5'd20}, 40'hFF_FFFF_FFFF, 1'b0);  // count above table size
    send_read(1000, 1600);
    configure(1, 40'hFF_FFFF_FFFF, 1'b1);
    send_read(1500, 10);
    send_read(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      noise = (ph % 3 == 2);
      if (noise) load_noise();
      else load_sorted();
      mode_sel = $urandom_range(0, 3);
      configure((ph == 1) ? 40'd0 : (ph == 3) ? 40'($urandom_range(17, 31)) :
                ($urandom_range(0, 1) != 0) ? 40'd16 : 40'($urandom_range(1, 16)),
                (mode_sel == 0) ? tbl_end : (mode_sel == 1) ? 40'hFF_FFFF_FFFF :
                (mode_sel == 2) ? rand40() : tbl_base + 40'($urandom_range(0, 3000)),
                1'($urandom));
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          while (pending != 0) @(posedge clk);
          @(negedge clk);
        end
        if ($urandom_range(0, 99) < 12) begin
          send_load(4'($urandom), rand40(), rand40(),
                    noise ? rand40() : 40'($urandom_range(0, 400)));
        end else begin
          off = noise ? rand40() :
                tbl_base + 40'($urandom_range(0, 32'(tbl_end - tbl_base) + 200));
          if (!noise && $urandom_range(0, 4) == 0 && off >= 100) off -= 100;
          case ($urandom_range(0, 9))
            0:       cnt = 0;
            1:       cnt = $urandom;
            default: cnt = $urandom_range(1, 1500);
          endcase
          send_read(off, cnt);
        end
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sparse_extent_read_translator.f @@
rtl/sext_pkg.sv
rtl/sext_table.sv
rtl/sparse_extent_read_translator.sv
tb/tb_sext_pkg.sv
tb/sext_checker.sv
tb/tb_top.sv
